>>> src/ppsa_pkg.sv
// Package: constants, arctangent table and pipeline data types for the steering angle block.
package ppsa_pkg;

	// Number of CORDIC rotation cells (range 8..30)
	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_N      = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

	// Field and datapath widths
	localparam int GOAL_W   = 32;
	localparam int WB_W     = 21;
	localparam int ANGLE_W  = 15;
	localparam int WIDE_W   = 64;
	localparam int Z_W      = 32;
	localparam int SHIFT_W  = 5;

	// Wheelbase reset value, 2.789 m in Q5.16
	localparam logic [WB_W-1:0] WB_RESET = WB_W'(182780);

	// pi/2 in Q2.30, clamp limit for the angle accumulator
	localparam logic signed [Z_W-1:0] ANG_HALF_PI = Z_W'(1686629713);

	// atan(2^-i) in Q2.30
	localparam logic signed [Z_W-1:0] ATAN_TAB [30] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	// Vector and angle state carried from cell to cell
	typedef struct packed {
		logic signed [WIDE_W-1:0] cx;
		logic signed [WIDE_W-1:0] cy;
		logic signed [Z_W-1:0]    z;
		logic                     yneg;
		logic                     zero;
	} cordic_data_t;

endpackage

>>> src/pure_pursuit_steering_angle.sv
// Pipeline: 5 front stages, CORDIC_N cells and 1 output stage.
// Throughput: one item per cycle while out_ready is high; every stage holds one item and moves
// whenever its successor frees, so bubbles close up under output stalls.
// The ready path runs combinationally back through the whole cell chain.
// Reset (arst_n low, asynchronous) empties every stage and sets the wheelbase to 2.789 m.
module pure_pursuit_steering_angle (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ppsa_pkg::WB_W-1:0]           cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ppsa_pkg::GOAL_W-1:0]  goal_forward,
	input  logic signed [ppsa_pkg::GOAL_W-1:0]  goal_lateral,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ppsa_pkg::ANGLE_W-1:0] steer_angle
);
	import ppsa_pkg::*;

	logic [WB_W-1:0] wheelbase_q;

	// chain links: index 0 is the front end output, CORDIC_N the last cell
	logic         c_vld [CORDIC_N+1];
	logic         c_rdy [CORDIC_N+1];
	cordic_data_t c_dat [CORDIC_N+1];

	logic                      out_valid_q;
	logic signed [ANGLE_W-1:0] steer_angle_q;
	logic                      out_en;
	logic signed [Z_W-1:0]     z_clamped;
	logic [Z_W-1:0]            z_round;
	logic [ANGLE_W-1:0]        mag;
	logic signed [ANGLE_W-1:0] angle_nxt;

	// wheelbase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= WB_RESET;
		end else if (cfg_wr_en) begin
			wheelbase_q <= cfg_wr_data;
		end
	end

	ppsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.wheelbase    (wheelbase_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.goal_forward (goal_forward),
		.goal_lateral (goal_lateral),
		.out_valid    (c_vld[0]),
		.out_ready    (c_rdy[0]),
		.out_data     (c_dat[0])
	);

	// CORDIC cell chain
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cell
		ppsa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (SHIFT_W'(i)),
			.angle     (ATAN_TAB[i]),
			.in_valid  (c_vld[i]),
			.in_ready  (c_rdy[i]),
			.in_data   (c_dat[i]),
			.out_valid (c_vld[i+1]),
			.out_ready (c_rdy[i+1]),
			.out_data  (c_dat[i+1])
		);
	end

	// output stage: clamp, round half up to Q2.13, apply sign
	assign out_en         = !out_valid_q || out_ready;
	assign c_rdy[CORDIC_N] = out_en;

	always_comb begin
		z_clamped = c_dat[CORDIC_N].z;
		if (z_clamped < 0) begin
			z_clamped = '0;
		end else if (z_clamped > ANG_HALF_PI) begin
			z_clamped = ANG_HALF_PI;
		end
		z_round = Z_W'(z_clamped) + Z_W'(1 << 16);
		mag     = ANGLE_W'(z_round[Z_W-1:17]);
		if (c_dat[CORDIC_N].zero) begin
			angle_nxt = '0;
		end else if (c_dat[CORDIC_N].yneg) begin
			angle_nxt = -$signed(mag);
		end else begin
			angle_nxt = $signed(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= c_vld[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			steer_angle_q <= angle_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign steer_angle = steer_angle_q;

	// result stays within -pi/2..pi/2
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (steer_angle >= -15'sd12868 && steer_angle <= 15'sd12868))
		else $error("steer angle out of range");

	// a degenerate goal or zero wheelbase yields exactly zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(c_vld[CORDIC_N] && out_en && c_dat[CORDIC_N].zero) |=> (out_valid && steer_angle == '0))
		else $error("degenerate item gave nonzero angle");

	// the sign follows the lateral offset
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(c_vld[CORDIC_N] && out_en && c_dat[CORDIC_N].yneg) |=> (out_valid && steer_angle <= 0))
		else $error("angle sign does not follow goal_lateral");

endmodule

>>> src/ppsa_front.sv
// Front end: magnitudes, wide products, sum and normalization of the CORDIC operands.
module ppsa_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ppsa_pkg::WB_W-1:0]         wheelbase,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ppsa_pkg::GOAL_W-1:0] goal_forward,
	input  logic signed [ppsa_pkg::GOAL_W-1:0] goal_lateral,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ppsa_pkg::cordic_data_t            out_data
);
	import ppsa_pkg::*;

	// stage valids and per-stage advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// s1: magnitudes
	logic [GOAL_W-1:0] ax_s1, ay_s1;
	logic              yneg_s1;
	// s2: products
	logic [WIDE_W-1:0]      sqx_s2, sqy_s2;
	logic [GOAL_W+WB_W-1:0] prod_s2;
	logic                   yneg_s2;
	// s3: operands
	logic [WIDE_W-1:0] den_s3, num_s3;
	logic              yneg_s3, zero_s3;
	// s4: coarse normalization
	logic [WIDE_W-1:0] den_s4, num_s4, or_s4;
	logic              yneg_s4, zero_s4;
	// s5: fine normalization
	logic [WIDE_W-1:0] den_s5, num_s5;
	logic              yneg_s5, zero_s5;

	logic [WIDE_W-1:0] den_a, num_a, or_a;
	logic [WIDE_W-1:0] den_b, num_b, or_b;

	// a stage loads when it is empty or its successor moves
	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// coarse shift: top bit of the OR word is the top bit of the larger operand
	always_comb begin
		den_a = den_s3;
		num_a = num_s3;
		or_a  = den_s3 | num_s3;
		if (or_a[63:32] == '0) begin
			den_a = den_a << 32; num_a = num_a << 32; or_a = or_a << 32;
		end
		if (or_a[63:48] == '0) begin
			den_a = den_a << 16; num_a = num_a << 16; or_a = or_a << 16;
		end
		if (or_a[63:56] == '0) begin
			den_a = den_a << 8; num_a = num_a << 8; or_a = or_a << 8;
		end
	end

	// fine shift, leaving the larger operand's top bit at bit 63
	always_comb begin
		den_b = den_s4;
		num_b = num_s4;
		or_b  = or_s4;
		if (or_b[63:60] == '0) begin
			den_b = den_b << 4; num_b = num_b << 4; or_b = or_b << 4;
		end
		if (or_b[63:62] == '0) begin
			den_b = den_b << 2; num_b = num_b << 2; or_b = or_b << 2;
		end
		if (!or_b[63]) begin
			den_b = den_b << 1; num_b = num_b << 1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1   <= goal_forward[GOAL_W-1] ? GOAL_W'(-goal_forward) : GOAL_W'(goal_forward);
			ay_s1   <= goal_lateral[GOAL_W-1] ? GOAL_W'(-goal_lateral) : GOAL_W'(goal_lateral);
			yneg_s1 <= goal_lateral[GOAL_W-1];
		end
		if (en2) begin
			sqx_s2  <= WIDE_W'(ax_s1) * WIDE_W'(ax_s1);
			sqy_s2  <= WIDE_W'(ay_s1) * WIDE_W'(ay_s1);
			prod_s2 <= (GOAL_W+WB_W)'(ay_s1) * (GOAL_W+WB_W)'(wheelbase);
			yneg_s2 <= yneg_s1;
		end
		if (en3) begin
			den_s3  <= sqx_s2 + sqy_s2;
			num_s3  <= WIDE_W'({prod_s2, 1'b0});
			zero_s3 <= (sqx_s2 == '0 && sqy_s2 == '0) || prod_s2 == '0;
			yneg_s3 <= yneg_s2;
		end
		if (en4) begin
			den_s4  <= den_a;
			num_s4  <= num_a;
			or_s4   <= or_a;
			zero_s4 <= zero_s3;
			yneg_s4 <= yneg_s3;
		end
		if (en5) begin
			den_s5  <= den_b;
			num_s5  <= num_b;
			zero_s5 <= zero_s4;
			yneg_s5 <= yneg_s4;
		end
	end

	// top bit moves down to bit 60, truncating
	assign out_valid     = v_s5;
	assign out_data.cx   = $signed(den_s5 >> 3);
	assign out_data.cy   = $signed(num_s5 >> 3);
	assign out_data.z    = '0;
	assign out_data.yneg = yneg_s5;
	assign out_data.zero = zero_s5;

endmodule

>>> src/ppsa_cell.sv
// One CORDIC vectoring cell: a fixed-shift micro-rotation and its output register.
module ppsa_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [ppsa_pkg::SHIFT_W-1:0]        shift,
	input  logic signed [ppsa_pkg::Z_W-1:0]     angle,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ppsa_pkg::cordic_data_t              in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ppsa_pkg::cordic_data_t              out_data
);
	import ppsa_pkg::*;

	logic                     valid_q;
	cordic_data_t             data_q;
	cordic_data_t             nxt;
	logic signed [WIDE_W-1:0] dx, dy;

	assign in_ready = !valid_q || out_ready;

	// rotate toward the x axis by the sign of y
	always_comb begin
		dx  = in_data.cy >>> shift;
		dy  = in_data.cx >>> shift;
		nxt = in_data;
		if (!in_data.cy[WIDE_W-1]) begin
			nxt.cx = in_data.cx + dx;
			nxt.cy = in_data.cy - dy;
			nxt.z  = in_data.z + angle;
		end else begin
			nxt.cx = in_data.cx - dx;
			nxt.cy = in_data.cy + dy;
			nxt.z  = in_data.z - angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
